// File: src/i2a_pkg.sv
`default_nettype none

package i2a_pkg;

  localparam int VALUE_W        = 32;
  localparam int NUM_DIGITS     = 10;
  localparam int DIGIT_W        = 4;
  localparam int DIG_IDX_W      = 4;
  localparam int BITS_PER_STAGE = 8;
  localparam int NUM_DABBLE     = VALUE_W / BITS_PER_STAGE;
  localparam int CHAR_W         = 8;

  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] i2a_bcd_t;

  typedef struct packed {
    logic               neg;
    i2a_bcd_t           bcd;
    logic [VALUE_W-1:0] bin;
  } i2a_work_t;

  typedef struct packed {
    logic     neg;
    i2a_bcd_t bcd;
  } i2a_digits_t;

endpackage

`default_nettype wire

// File: src/i2a_dabble.sv
`default_nettype none

module i2a_dabble (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_vld,
  input  wire i2a_pkg::i2a_work_t up_data,
  output logic                    up_rdy,
  output logic                    dn_vld,
  output i2a_pkg::i2a_work_t      dn_data,
  input  wire logic               dn_rdy
);
  import i2a_pkg::*;

  logic      vld_r;
  i2a_work_t data_r;
  i2a_work_t data_nxt;

  // shift-add-3 over a slice of the binary word
  always_comb begin
    i2a_bcd_t           bcd;
    logic [VALUE_W-1:0] bin;
    bcd = up_data.bcd;
    bin = up_data.bin;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd[d] >= DABBLE_MIN) begin
          bcd[d] = bcd[d] + DABBLE_ADD;
        end
      end
      {bcd, bin} = {bcd, bin} << 1;
    end
    data_nxt.neg = up_data.neg;
    data_nxt.bcd = bcd;
    data_nxt.bin = bin;
  end

  assign up_rdy  = !vld_r || dn_rdy;
  assign dn_vld  = vld_r;
  assign dn_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/i2a_emit.sv
`default_nettype none

module i2a_emit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          up_vld,
  input  wire i2a_pkg::i2a_digits_t          up_data,
  output logic                               up_rdy,
  output logic                               out_vld,
  output logic [i2a_pkg::CHAR_W-1:0]         out_code,
  output logic                               out_last
);
  import i2a_pkg::*;

  logic                 act_r;
  logic                 sign_r;
  logic [DIG_IDX_W-1:0] idx_r;
  i2a_bcd_t             digits_r;
  logic [DIG_IDX_W-1:0] top_nxt;
  logic                 done;
  logic                 out_vld_r;
  logic [CHAR_W-1:0]    out_code_r;
  logic                 out_last_r;
  logic [CHAR_W-1:0]    code_nxt;
  logic                 last_nxt;

  // index of the most significant nonzero digit, zero for a zero value
  always_comb begin
    top_nxt = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (up_data.bcd[i] != '0) begin
        top_nxt = DIG_IDX_W'(i);
      end
    end
  end

  assign done   = act_r && !sign_r && (idx_r == '0);
  assign up_rdy = !act_r || done;

  always_comb begin
    if (sign_r) begin
      code_nxt = CHAR_MINUS;
      last_nxt = 1'b0;
    end else begin
      code_nxt = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits_r[idx_r]};
      last_nxt = (idx_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= act_r;
      if (up_rdy) begin
        act_r <= up_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      sign_r   <= up_data.neg;
      idx_r    <= top_nxt;
      digits_r <= up_data.bcd;
    end else if (sign_r) begin
      sign_r <= 1'b0;
    end else begin
      idx_r <= idx_r - 1'b1;
    end
    out_code_r <= code_nxt;
    out_last_r <= last_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_code = out_code_r;
  assign out_last = out_last_r;

endmodule

`default_nettype wire

// File: src/int32_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text.
// Input: in_value is transferred at a rising edge with start high and busy low.
// Output: one character per cycle on out_char_code, marked by out_valid for
// exactly one cycle; out_last_char flags the final character of a number.
// A negative number starts with '-', digits follow most significant first
// with no leading zeros, and zero gives a single '0'. A run is 1 to 11 chars.
// A number passes a sign/negate stage, four binary-to-BCD stages of 8 bits
// each, a loader and an output register before its first character shows.
// The character serializer takes a new number only when the current one is
// on its last character; characters of consecutive numbers follow with no
// gap when the next number is already waiting.
// busy rises when the pipeline backs up behind the serializer; the pipeline
// stages hold their contents then and nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties all stages and drops any pending
// characters. The receiver cannot stall: every strobed character is taken.
`default_nettype none

module int32_to_decimal_ascii (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [31:0]           in_value,
  output logic                              out_valid,
  output logic [7:0]                        out_char_code,
  output logic                              out_last_char
);
  import i2a_pkg::*;

  logic               s0_vld_r;
  logic               s0_neg_r;
  logic [VALUE_W-1:0] s0_mag_r;
  logic               s0_rdy;
  logic [VALUE_W-1:0] raw;

  logic      [NUM_DABBLE:0] d_vld;
  logic      [NUM_DABBLE:0] d_rdy;
  i2a_work_t [NUM_DABBLE:0] d_data;
  i2a_digits_t              em_data;

  assign raw    = $unsigned(in_value);
  assign s0_rdy = !s0_vld_r || d_rdy[0];
  assign busy   = !s0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy) begin
      s0_neg_r <= raw[VALUE_W-1];
      s0_mag_r <= raw[VALUE_W-1] ? ('0 - raw) : raw;
    end
  end

  assign d_vld[0]      = s0_vld_r;
  assign d_data[0].neg = s0_neg_r;
  assign d_data[0].bcd = '0;
  assign d_data[0].bin = s0_mag_r;

  for (genvar g = 0; g < NUM_DABBLE; g++) begin : g_dabble
    i2a_dabble u_dabble (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_vld  (d_vld[g]),
      .up_data (d_data[g]),
      .up_rdy  (d_rdy[g]),
      .dn_vld  (d_vld[g+1]),
      .dn_data (d_data[g+1]),
      .dn_rdy  (d_rdy[g+1])
    );
  end

  assign em_data.neg = d_data[NUM_DABBLE].neg;
  assign em_data.bcd = d_data[NUM_DABBLE].bcd;

  i2a_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (d_vld[NUM_DABBLE]),
    .up_data  (em_data),
    .up_rdy   (d_rdy[NUM_DABBLE]),
    .out_vld  (out_valid),
    .out_code (out_char_code),
    .out_last (out_last_char)
  );

endmodule

`default_nettype wire

// File: src/i2a_checker.sv
`default_nettype none

module i2a_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic [7:0]         out_char_code,
  input wire logic               out_last_char
);
  import i2a_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("character strobed right after reset");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == CHAR_MINUS) ||
                  (out_char_code >= CHAR_ZERO && out_char_code <= CHAR_ZERO + 8'd9))
    else $error("character outside minus and digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == CHAR_MINUS |-> !out_last_char)
    else $error("minus sign flagged as last");

  a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == CHAR_MINUS |=> out_valid && out_char_code != CHAR_MINUS)
    else $error("minus sign not followed by a digit");

  a_no_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !busy)
    else $error("busy right after reset");

endmodule

bind int32_to_decimal_ascii i2a_checker u_i2a_checker (.*);

`default_nettype wire
